// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds in the cycle the antecedent holds.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tce_pkg.sv -----
// ----------------------------------------------------------------------------
// tce_pkg
// Types, sizes and codes shared by the threshold cluster extractor modules.
// ----------------------------------------------------------------------------
package tce_pkg;

    localparam int PRE_DEPTH   = 16;
    localparam int SAMPLE_BITS = 10;
    localparam int FRAME_MAX   = 1024;

    localparam int POS_W       = 10;
    localparam int THR_W       = 10;
    localparam int PRE_CNT_W   = 4;
    localparam int POST_CNT_W  = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;

    localparam int HIST_DEPTH  = PRE_DEPTH + 1;
    localparam int HIST_IDX_W  = $clog2(HIST_DEPTH);
    localparam int FILL_W      = $clog2(PRE_DEPTH + 1);
    localparam int CMP_W       = (FILL_W > PRE_CNT_W) ? FILL_W : PRE_CNT_W;
    localparam int IDXC_W      = ((HIST_IDX_W > PRE_CNT_W) ? HIST_IDX_W : PRE_CNT_W) + 1;

    localparam int POS_CAP_INT = (FRAME_MAX - 1 > 1023) ? 1023 : FRAME_MAX - 1;
    localparam logic [POS_W-1:0] POS_CAP = POS_CAP_INT[POS_W-1:0];

    localparam logic [THR_W-1:0]      THR_RESET  = 10'd110;
    localparam logic [PRE_CNT_W-1:0]  PRE_RESET  = 4'd3;
    localparam logic [POST_CNT_W-1:0] POST_RESET = 7'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_COUNT = 2'd2;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_ABOVE,
        PH_POST,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_PRE,
        CS_HELD,
        CS_CUR
    } ctrl_state_t;

    typedef struct packed {
        logic ready;
        logic accept;
        logic load_pre;
        logic load_held;
        logic load_cur;
    } tce_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic plan_pre;
        logic plan_held;
        logic plan_cur;
        logic pend_held;
        logic pend_cur;
        logic pre_last;
    } tce_status_t;

endpackage

// ----- rtl/tce_ctrl.sv -----
// ----------------------------------------------------------------------------
// tce_ctrl
// Sequencer: accepts one sample transaction, then steps the datapath through its
// pre, held and current samples, one result per cycle while output is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tce_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  tce_pkg::tce_status_t sts,
    output tce_pkg::tce_cmd_t    cmd
);
    import tce_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE:
            begin
                if (sts.in_valid)
                begin
                    priority if (sts.plan_pre)  state_next = CS_PRE;
                    else if (sts.plan_held)     state_next = CS_HELD;
                    else if (sts.plan_cur)      state_next = CS_CUR;
                    else                        state_next = CS_IDLE;
                end
            end
            CS_PRE:
            begin
                if (sts.out_free && sts.pre_last)
                begin
                    priority if (sts.pend_held) state_next = CS_HELD;
                    else if (sts.pend_cur)      state_next = CS_CUR;
                    else                        state_next = CS_IDLE;
                end
            end
            CS_HELD:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.pend_cur ? CS_CUR : CS_IDLE;
                end
            end
            CS_CUR:
            begin
                if (sts.out_free)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            CS_IDLE:
            begin
                cmd.ready  = 1'b1;
                cmd.accept = sts.in_valid;
            end
            CS_PRE:
            begin
                cmd.load_pre = sts.out_free;
            end
            CS_HELD:
            begin
                cmd.load_held = sts.out_free;
            end
            CS_CUR:
            begin
                cmd.load_cur = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `ASSERT_IMPLIES(a_load_needs_room, cmd.load_pre || cmd.load_held || cmd.load_cur, sts.out_free, "result loaded while output register busy")
    `ASSERT_ALWAYS(a_one_load, $onehot0({cmd.accept, cmd.load_pre, cmd.load_held, cmd.load_cur}), "more than one command in a cycle")

endmodule

// ----- rtl/tce_datapath.sv -----
// ----------------------------------------------------------------------------
// tce_datapath
// Configuration registers, sample history, frame and cluster state, item
// latch and the output register that holds one result transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tce_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [tce_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [tce_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  sample_valid,
    input  logic [tce_pkg::SAMPLE_BITS-1:0]       sample,
    input  logic                                  frame_end,
    input  logic                                  result_stall,
    input  tce_pkg::tce_cmd_t                     cmd,
    output tce_pkg::tce_status_t                  sts,
    output logic                                  result_valid,
    output logic [tce_pkg::SAMPLE_BITS-1:0]       value,
    output logic [tce_pkg::POS_W-1:0]             position,
    output logic                                  cluster_last
);
    import tce_pkg::*;

    logic [THR_W-1:0]       thr_reg;
    logic [PRE_CNT_W-1:0]   pre_count_reg;
    logic [POST_CNT_W-1:0]  post_count_reg;

    logic [SAMPLE_BITS-1:0] hist_reg [HIST_DEPTH];
    logic [FILL_W-1:0]      fill_reg,      fill_next;
    logic [POS_W-1:0]       frame_pos_reg, frame_pos_next;
    phase_t                 phase_reg,     phase_next;
    logic [POST_CNT_W-1:0]  post_left_reg, post_left_next;

    logic [SAMPLE_BITS-1:0] item_sample_reg;
    logic [POS_W-1:0]       item_pos_reg;
    logic                   pushed_reg;
    logic [SAMPLE_BITS-1:0] held_val_reg;
    logic [POS_W-1:0]       held_pos_reg;
    logic                   held_last_reg;
    logic                   cur_last_reg;
    logic [PRE_CNT_W-1:0]   pre_left_reg,  pre_left_next;
    logic                   pend_held_reg, pend_held_next;
    logic                   pend_cur_reg,  pend_cur_next;

    logic                   result_valid_reg, result_valid_next;
    logic [SAMPLE_BITS-1:0] out_value_reg,    out_value_next;
    logic [POS_W-1:0]       out_pos_reg,      out_pos_next;
    logic                   out_last_reg,     out_last_next;

    logic                   above_thr;
    logic                   at_or_above;
    logic [CMP_W-1:0]       fill_ext;
    logic [CMP_W-1:0]       pre_ext;
    logic [PRE_CNT_W-1:0]   pre_cnt;
    logic                   hist_push;
    logic                   hist_wr0;
    logic [PRE_CNT_W-1:0]   plan_pre_cnt;
    logic                   plan_held;
    logic                   plan_held_last;
    logic                   plan_cur;
    logic                   plan_cur_last;
    logic [POST_CNT_W-1:0]  post_dec;
    logic [IDXC_W-1:0]      rd_idx_wide;
    logic [HIST_IDX_W-1:0]  rd_idx;
    logic [POS_W-1:0]       pre_dist;
    logic [POS_W-1:0]       pre_pos;
    logic                   out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= THR_RESET;
            pre_count_reg  <= PRE_RESET;
            post_count_reg <= POST_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:  thr_reg        <= cfg_data[THR_W-1:0];
                CFG_PRE_COUNT:  pre_count_reg  <= cfg_data[PRE_CNT_W-1:0];
                CFG_POST_COUNT: post_count_reg <= cfg_data[POST_CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    assign above_thr   = sample > thr_reg;
    assign at_or_above = sample >= thr_reg;
    assign fill_ext    = CMP_W'(fill_reg);
    assign pre_ext     = CMP_W'(pre_count_reg);
    assign pre_cnt     = (pre_ext < fill_ext) ? pre_count_reg : fill_reg[PRE_CNT_W-1:0];
    assign post_dec    = post_left_reg - POST_CNT_W'(1);

    always_comb
    begin
        hist_push      = 1'b0;
        hist_wr0       = 1'b0;
        plan_pre_cnt   = '0;
        plan_held      = 1'b0;
        plan_held_last = 1'b0;
        plan_cur       = 1'b0;
        plan_cur_last  = 1'b0;
        phase_next     = phase_reg;
        post_left_next = post_left_reg;
        fill_next      = fill_reg;
        frame_pos_next = frame_pos_reg;

        unique case (phase_reg)
            PH_SEARCH:
            begin
                if (above_thr)
                begin
                    plan_pre_cnt  = pre_cnt;
                    plan_cur      = frame_end;
                    plan_cur_last = 1'b1;
                    if (!frame_end)
                    begin
                        hist_push  = 1'b1;
                        phase_next = PH_ABOVE;
                    end
                end
                else
                begin
                    hist_push = 1'b1;
                end
            end
            PH_ABOVE:
            begin
                plan_held = 1'b1;
                if (at_or_above)
                begin
                    plan_cur      = frame_end;
                    plan_cur_last = 1'b1;
                    hist_wr0      = !frame_end;
                end
                else if (post_count_reg == '0)
                begin
                    plan_held_last = 1'b1;
                    phase_next     = PH_DONE;
                end
                else
                begin
                    post_left_next = post_count_reg - POST_CNT_W'(1);
                    plan_cur       = 1'b1;
                    plan_cur_last  = (post_left_next == '0) || frame_end;
                    phase_next     = (post_left_next == '0) ? PH_DONE : PH_POST;
                end
            end
            PH_POST:
            begin
                if (post_left_reg != '0)
                begin
                    post_left_next = post_dec;
                end
                plan_cur      = 1'b1;
                plan_cur_last = (post_left_next == '0) || frame_end;
                if (post_left_next == '0)
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                phase_next = PH_DONE;
            end
            default:
            begin
                phase_next = PH_SEARCH;
            end
        endcase

        if (hist_push && fill_reg != FILL_W'(PRE_DEPTH))
        begin
            fill_next = fill_reg + FILL_W'(1);
        end

        if (frame_end)
        begin
            frame_pos_next = '0;
            fill_next      = '0;
            phase_next     = PH_SEARCH;
            post_left_next = '0;
        end
        else if (frame_pos_reg < POS_CAP)
        begin
            frame_pos_next = frame_pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            frame_pos_reg <= '0;
            phase_reg     <= PH_SEARCH;
            post_left_reg <= '0;
        end
        else if (cmd.accept)
        begin
            fill_reg      <= fill_next;
            frame_pos_reg <= frame_pos_next;
            phase_reg     <= phase_next;
            post_left_reg <= post_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            if (hist_push)
            begin
                for (int i = HIST_DEPTH - 1; i > 0; i--)
                begin
                    hist_reg[i] <= hist_reg[i-1];
                end
                hist_reg[0] <= sample;
            end
            else if (hist_wr0)
            begin
                hist_reg[0] <= sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_sample_reg <= sample;
            item_pos_reg    <= frame_pos_reg;
            pushed_reg      <= hist_push;
            held_val_reg    <= hist_reg[0];
            held_pos_reg    <= (frame_pos_reg == '0) ? '0 : frame_pos_reg - POS_W'(1);
            held_last_reg   <= plan_held_last;
            cur_last_reg    <= plan_cur_last;
        end
    end

    assign rd_idx_wide = IDXC_W'(pre_left_reg) - IDXC_W'(1) + IDXC_W'(pushed_reg);
    assign rd_idx      = rd_idx_wide[HIST_IDX_W-1:0];
    assign pre_dist    = POS_W'(pre_left_reg);
    assign pre_pos     = (item_pos_reg >= pre_dist) ? item_pos_reg - pre_dist : '0;
    assign out_free    = !result_valid_reg || !result_stall;

    always_comb
    begin
        pre_left_next  = pre_left_reg;
        pend_held_next = pend_held_reg;
        pend_cur_next  = pend_cur_reg;
        if (cmd.accept)
        begin
            pre_left_next  = plan_pre_cnt;
            pend_held_next = plan_held;
            pend_cur_next  = plan_cur;
        end
        else if (cmd.load_pre)
        begin
            pre_left_next = pre_left_reg - PRE_CNT_W'(1);
        end
        else if (cmd.load_held)
        begin
            pend_held_next = 1'b0;
        end
        else if (cmd.load_cur)
        begin
            pend_cur_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_left_reg  <= '0;
            pend_held_reg <= 1'b0;
            pend_cur_reg  <= 1'b0;
        end
        else
        begin
            pre_left_reg  <= pre_left_next;
            pend_held_reg <= pend_held_next;
            pend_cur_reg  <= pend_cur_next;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        out_value_next    = out_value_reg;
        out_pos_next      = out_pos_reg;
        out_last_next     = out_last_reg;
        priority if (cmd.load_pre)
        begin
            result_valid_next = 1'b1;
            out_value_next    = hist_reg[rd_idx];
            out_pos_next      = pre_pos;
            out_last_next     = 1'b0;
        end
        else if (cmd.load_held)
        begin
            result_valid_next = 1'b1;
            out_value_next    = held_val_reg;
            out_pos_next      = held_pos_reg;
            out_last_next     = held_last_reg;
        end
        else if (cmd.load_cur)
        begin
            result_valid_next = 1'b1;
            out_value_next    = item_sample_reg;
            out_pos_next      = item_pos_reg;
            out_last_next     = cur_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_pos_reg   <= out_pos_next;
        out_last_reg  <= out_last_next;
    end

    assign result_valid = result_valid_reg;
    assign value        = out_value_reg;
    assign position     = out_pos_reg;
    assign cluster_last = out_last_reg;

    always_comb
    begin
        sts           = '0;
        sts.in_valid  = sample_valid;
        sts.out_free  = out_free;
        sts.plan_pre  = plan_pre_cnt != '0;
        sts.plan_held = plan_held;
        sts.plan_cur  = plan_cur;
        sts.pend_held = pend_held_reg;
        sts.pend_cur  = pend_cur_reg;
        sts.pre_last  = pre_left_reg == PRE_CNT_W'(1);
    end

    `ASSERT_NEXT(a_done_is_silent, cmd.accept && phase_reg == PH_DONE && !frame_end, (pre_left_reg == '0) && !pend_held_reg && !pend_cur_reg, "sample after cluster scheduled a result")
    `ASSERT_ALWAYS(a_pos_capped, frame_pos_reg <= POS_CAP, "frame position beyond its cap")

endmodule

// ----- rtl/threshold_cluster_extractor_top.sv -----
// ----------------------------------------------------------------------------
// threshold_cluster_extractor_top
// Zero suppression of framed ADC samples: one cluster per frame, with pre
// samples before the threshold crossing and post samples after it.
// ----------------------------------------------------------------------------
// A sample yielding no result does not stall the input; one yielding n results
// (n up to 16: up to fifteen pre samples and a crossing sample that ends its
// frame, or the held sample and the current one) stalls the input until the
// last is loaded, as the single output register takes one result per cycle
// while free. The next sample is taken the cycle after the last result is
// loaded, while that result still waits in the output register. A stalled
// output freezes the sequencer until it drains. Configuration must be written
// via cfg_we / cfg_index / cfg_data by the user only while idle (not enforced).
// ----------------------------------------------------------------------------
module threshold_cluster_extractor_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tce_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tce_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            sample_valid,
    output logic                            sample_stall,
    input  logic [tce_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                            frame_end,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic [tce_pkg::SAMPLE_BITS-1:0] value,
    output logic [tce_pkg::POS_W-1:0]       position,
    output logic                            cluster_last
);
    import tce_pkg::*;

    tce_cmd_t    cmd;
    tce_status_t sts;

    tce_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    tce_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample       (sample),
        .frame_end    (frame_end),
        .result_stall (result_stall),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .value        (value),
        .position     (position),
        .cluster_last (cluster_last)
    );

    assign sample_stall = !cmd.ready;

endmodule
